// ===== hw/rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

    // Step counter width: eight control words
    localparam int PC_W   = 3;
    localparam int IDX_W  = 3;
    localparam int Q_FRAC = 16;
    localparam int OPD_W  = 33;             // multiplier operand width
    localparam int PRD_W  = 2 * OPD_W;      // full product width
    localparam int PQ_W   = PRD_W - Q_FRAC; // product back in Q34.16
    localparam int ACC_W  = PQ_W + 2;       // sum of three terms

    // Register indexes
    localparam logic [IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [IDX_W-1:0] REG_RATE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd5;

    // Multiplier operand pair selects
    localparam logic [2:0] MS_NONE  = 3'd0;
    localparam logic [2:0] MS_DRATE = 3'd1;  // (err - prev) * rate
    localparam logic [2:0] MS_EPER  = 3'd2;  // err * period
    localparam logic [2:0] MS_KPERR = 3'd3;  // kp * err
    localparam logic [2:0] MS_KDDER = 3'd4;  // kd * deriv
    localparam logic [2:0] MS_KIINT = 3'd5;  // ki * integ

    // Datapath operations on the registered product
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_ERR      = 3'd1;
    localparam logic [2:0] OP_DERIV    = 3'd2;
    localparam logic [2:0] OP_INTEG    = 3'd3;
    localparam logic [2:0] OP_ACC_LOAD = 3'd4;
    localparam logic [2:0] OP_ACC_ADD  = 3'd5;
    localparam logic [2:0] OP_DONE     = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] msel;
        logic       wait_out;  // hold here while the result register is full
        logic       last;      // end of program
    } ctl_word_t;

    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic [30:0]        period;
        logic [30:0]        rate;
        logic [30:0]        limit;
    } cfg_t;

    // Control program, one word per step
    function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        w = '{op: OP_NOP, msel: MS_NONE, wait_out: 1'b0, last: 1'b0};
        case (pc)
            3'd0: w.op = OP_ERR;
            3'd1: w.msel = MS_DRATE;
            3'd2: begin w.op = OP_DERIV;    w.msel = MS_EPER;  end
            3'd3: begin w.op = OP_INTEG;    w.msel = MS_KPERR; end
            3'd4: begin w.op = OP_ACC_LOAD; w.msel = MS_KDDER; end
            3'd5: begin w.op = OP_ACC_ADD;  w.msel = MS_KIINT; end
            3'd6: w.op = OP_ACC_ADD;
            3'd7: begin w.op = OP_DONE; w.wait_out = 1'b1; w.last = 1'b1; end
            default: w.op = OP_NOP;
        endcase
        return w;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff}))
            r = 32'sh7fff_ffff;
        else if (x < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/pidc_datapath.sv =====
`timescale 1ns / 1ps

module pidc_datapath
    import pidc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               load,
    input  logic signed [31:0] in_setpoint,
    input  logic signed [31:0] in_measured,
    input  logic               step_en,
    input  ctl_word_t          ctl,
    output logic signed [31:0] drive
);

    logic signed [31:0]      sp_reg, fb_reg, err_reg, deriv_reg, integ_reg, drive_reg;
    logic signed [31:0]      prev_reg, isum_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [OPD_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] mul_p;
    logic signed [PQ_W-1:0]  prod_q;
    logic signed [ACC_W-1:0] prod_x, err_wide, integ_sum, lim_pos, lim_neg;
    logic signed [31:0]      integ_clamp;

    // Pick multiplier operands
    always_comb
    begin
        case (ctl.msel)
            MS_DRATE:
            begin
                mul_a = {err_reg[31], err_reg} - {prev_reg[31], prev_reg};
                mul_b = {2'b00, cfg.rate};
            end
            MS_EPER:
            begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {2'b00, cfg.period};
            end
            MS_KPERR:
            begin
                mul_a = {cfg.kp[31], cfg.kp};
                mul_b = {err_reg[31], err_reg};
            end
            MS_KDDER:
            begin
                mul_a = {cfg.kd[31], cfg.kd};
                mul_b = {deriv_reg[31], deriv_reg};
            end
            MS_KIINT:
            begin
                mul_a = {cfg.ki[31], cfg.ki};
                mul_b = {integ_reg[31], integ_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    // Arithmetic shift by the fraction width rounds toward minus infinity
    assign prod_q = prod_reg[PRD_W-1:Q_FRAC];
    assign prod_x = {{(ACC_W-PQ_W){prod_q[PQ_W-1]}}, prod_q};

    assign err_wide = {{(ACC_W-32){sp_reg[31]}}, sp_reg}
                    - {{(ACC_W-32){fb_reg[31]}}, fb_reg};

    // Add integral step and clamp to the symmetric limit
    assign integ_sum = {{(ACC_W-32){isum_reg[31]}}, isum_reg} + prod_x;
    assign lim_pos   = {{(ACC_W-31){1'b0}}, cfg.limit};
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        if (integ_sum > lim_pos)
            integ_clamp = lim_pos[31:0];
        else if (integ_sum < lim_neg)
            integ_clamp = lim_neg[31:0];
        else
            integ_clamp = integ_sum[31:0];
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sp_reg <= in_setpoint;
            fb_reg <= in_measured;
        end
    end

    // Working registers driven by the control word
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (ctl.msel != MS_NONE)
                prod_reg <= mul_p;
            case (ctl.op)
                OP_ERR:      err_reg   <= sat32(err_wide);
                OP_DERIV:    deriv_reg <= sat32(prod_x);
                OP_INTEG:    integ_reg <= integ_clamp;
                OP_ACC_LOAD: acc_reg   <= prod_x;
                OP_ACC_ADD:  acc_reg   <= acc_reg + prod_x;
                OP_DONE:     drive_reg <= sat32(acc_reg);
                default:     ;
            endcase
        end
    end

    // Controller state kept between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            isum_reg <= '0;
        end
        else if (step_en && ctl.op == OP_DONE)
        begin
            prev_reg <= err_reg;
            isum_reg <= integ_reg;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== hw/rtl/pid_controller_clamped_integral.sv =====
`timescale 1ns / 1ps

// PID controller with a clamped integral, values in Q16.16 (signed, but
// period, rate and limit unsigned). Each input item (setpoint, measured)
// yields one drive item. The error is saturated, the derivative is (error -
// previous error) * sample_rate saturated, and the integral adds error *
// sample_period and is clamped to +/- integral_limit. Each tick runs an
// eight-step control program over one shared 33x33 multiplier, and the next
// item is accepted the cycle after the program ends; the last step waits
// while a previous result has not been taken. Configuration writes (index
// 0..5: kp, ki, kd, period, rate, limit) are taken at any time and must only
// be made while no item is in flight.

module pid_controller_clamped_integral
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input item stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [31:0] setpoint, [63:32] measured
    // Result item stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [31:0] drive
    // Configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [31:0]       cfg_data
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    cfg_t            cfg_reg;
    ctl_word_t       ctl;
    logic            in_fire, out_fire, step_en, stall;
    logic            done_fire;

    assign ctl       = ucode(pc_reg);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign stall     = ctl.wait_out && out_valid_reg && !m_axis_tready;
    assign step_en   = busy_reg && !stall;
    assign done_fire = step_en && ctl.op == OP_DONE;

    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP:     cfg_reg.kp     <= cfg_data;
                REG_KI:     cfg_reg.ki     <= cfg_data;
                REG_KD:     cfg_reg.kd     <= cfg_data;
                REG_PERIOD: cfg_reg.period <= cfg_data[30:0];
                REG_RATE:   cfg_reg.rate   <= cfg_data[30:0];
                REG_LIMIT:  cfg_reg.limit  <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    // Sequencer: start on accept, advance unless held, stop at the last word
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (step_en)
        begin
            if (ctl.last)
                busy_next = 1'b0;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_fire)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pidc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .load        (in_fire),
        .in_setpoint (s_axis_tdata[31:0]),
        .in_measured (s_axis_tdata[63:32]),
        .step_en     (step_en),
        .ctl         (ctl),
        .drive       (m_axis_tdata)
    );

endmodule
